FILE: design/rts_pkg.sv
// Shared widths, codes and reset values for the runway takeoff sequencer.
`default_nettype none

package rts_pkg;

   // Field widths.
   localparam int TIME_W  = 48;
   localparam int RAMP_W  = 26;
   localparam int AIR_W   = 15;
   localparam int ALT_W   = 25;
   localparam int ANG_W   = 13;
   localparam int THR_W   = 10;
   localparam int OVR_W   = 12;
   localparam int CMD_W   = 2;
   localparam int PHASE_W = 2;
   localparam int CSR_W   = 26;
   localparam int CSR_IDX_W = 3;
   localparam int PROD_W  = RAMP_W + THR_W;
   localparam int CNT_W   = $clog2(TIME_W);

   // Command codes.
   localparam logic [CMD_W-1:0] CMD_RESET  = 2'd0;
   localparam logic [CMD_W-1:0] CMD_START  = 2'd1;
   localparam logic [CMD_W-1:0] CMD_UPDATE = 2'd2;

   // Phase codes.
   localparam logic [PHASE_W-1:0] PH_RAMP    = 2'd0;
   localparam logic [PHASE_W-1:0] PH_RUNWAY  = 2'd1;
   localparam logic [PHASE_W-1:0] PH_CLIMB   = 2'd2;
   localparam logic [PHASE_W-1:0] PH_FLY     = 2'd3;

   // Configuration register indexes.
   localparam logic [CSR_IDX_W-1:0] CSR_RAMP_TIME    = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_TAKEOFF_AIR  = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_RUNWAY_PITCH = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_THROTTLE = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_HOLD_HEADING = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_PITCH_OVR    = 3'd5;

   // Configuration reset values.
   localparam logic [RAMP_W-1:0] RAMP_TIME_RST    = 26'd2000000;
   localparam logic [AIR_W-1:0]  TAKEOFF_AIR_RST  = 15'd1300;
   localparam logic [ANG_W-1:0]  RUNWAY_PITCH_RST = 13'd0;
   localparam logic [THR_W-1:0]  MAX_THROTTLE_RST = 10'd1000;
   localparam logic              HOLD_HEADING_RST = 1'b1;
   localparam logic [OVR_W-1:0]  PITCH_OVR_RST    = 12'd0;

   // The pitch override counts only above this value.
   localparam logic [OVR_W-1:0]  PITCH_OVR_MIN    = 12'd1;

   // Sequencer control states.
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SERIAL,
      ST_DECIDE,
      ST_MUL,
      ST_DIV,
      ST_OUT
   } state_type;

endpackage

`default_nettype wire

FILE: design/runway_takeoff_sequencer.sv
// Runway takeoff sequencer: bit-serial time and threshold compares, serial ramp divider.
// An accepted transfer runs the bit-serial subtract and compare pass, then a decide step and,
// when the ramp throttle has to be computed (phase 0, ramp time nonzero, ramp not yet elapsed),
// the shift-add multiply and the restoring divide, before its result is loaded for output.
// The input stalls until then: a new transfer is taken only once the last one is through.
// A finished result waits in the output register while the next transfer is taken.
// Reset (synchronous, active high) clears the phase, flags, start time and held yaw and loads
// the configuration registers with their default values.
`default_nettype none

module runway_takeoff_sequencer (
   input  wire logic                               clock,
   input  wire logic                               reset,
   // Configuration port.
   input  wire logic                               csr_write,
   input  wire logic [rts_pkg::CSR_IDX_W-1:0]      csr_index,
   input  wire logic [rts_pkg::CSR_W-1:0]          csr_data,
   // Input channel.
   input  wire logic                               req_valid,
   output logic                                    req_stall,
   input  wire logic [rts_pkg::CMD_W-1:0]          req_command,
   input  wire logic [rts_pkg::TIME_W-1:0]         req_time_us,
   input  wire logic [rts_pkg::AIR_W-1:0]          req_airspeed,
   input  wire logic signed [rts_pkg::ALT_W-1:0]   req_altitude,
   input  wire logic signed [rts_pkg::ALT_W-1:0]   req_clearance_alt,
   input  wire logic signed [rts_pkg::ANG_W-1:0]   req_ext_pitch,
   input  wire logic signed [rts_pkg::ANG_W-1:0]   req_ext_roll,
   input  wire logic signed [rts_pkg::ANG_W-1:0]   req_ext_yaw,
   input  wire logic [rts_pkg::THR_W-1:0]          req_ext_throttle,
   input  wire logic signed [rts_pkg::ANG_W-1:0]   req_climb_min_pitch,
   input  wire logic signed [rts_pkg::ANG_W-1:0]   req_normal_min_pitch,
   input  wire logic signed [rts_pkg::ANG_W-1:0]   req_normal_max_pitch,
   // Result channel.
   output logic                                    rsp_valid,
   input  wire logic                               rsp_stall,
   output logic [rts_pkg::PHASE_W-1:0]             rsp_phase,
   output logic signed [rts_pkg::ANG_W-1:0]        rsp_pitch_out,
   output logic signed [rts_pkg::ANG_W-1:0]        rsp_roll_out,
   output logic signed [rts_pkg::ANG_W-1:0]        rsp_yaw_out,
   output logic [rts_pkg::THR_W-1:0]               rsp_throttle_out,
   output logic                                    rsp_yaw_direct,
   output logic                                    rsp_clear_integrators,
   output logic signed [rts_pkg::ANG_W-1:0]        rsp_min_pitch_out,
   output logic signed [rts_pkg::ANG_W-1:0]        rsp_max_pitch_out,
   output logic                                    rsp_in_climbout,
   output logic                                    rsp_started
);

   import rts_pkg::*;

   // Configuration registers.
   logic [RAMP_W-1:0]       ramp_time_ff;
   logic [AIR_W-1:0]        takeoff_air_ff;
   logic signed [ANG_W-1:0] runway_pitch_ff;
   logic [THR_W-1:0]        max_throttle_ff;
   logic                    hold_heading_ff;
   logic [OVR_W-1:0]        pitch_ovr_ff;

   // Sequencer state.
   logic [PHASE_W-1:0]      phase_ff, phase_in;
   logic [TIME_W-1:0]       start_time_ff, start_time_in;
   logic signed [ANG_W-1:0] held_yaw_ff, held_yaw_in;
   logic                    climbout_ff, climbout_in;
   logic                    init_ff, init_in;

   // Control.
   state_type               state_ff, state_in;
   logic [CNT_W-1:0]        cnt_ff, cnt_in;
   logic                    req_accept;
   logic                    out_load;
   logic                    need_ramp;
   logic                    use_quot_ff;

   // Captured payload of the transfer in progress.
   logic [CMD_W-1:0]        cmd_ff;
   logic signed [ANG_W-1:0] pitch_ff, roll_ff, yaw_ff;
   logic [THR_W-1:0]        thr_ff;
   logic signed [ANG_W-1:0] cmin_ff, nmin_ff, nmax_ff;

   // Bit-serial operands and compare results.
   logic [TIME_W-1:0]       now_sr_ff, start_sr_ff;
   logic                    borrow_ff;
   logic [RAMP_W-1:0]       ela_sr_ff, ramp_sr_ff;
   logic [AIR_W-1:0]        air_sr_ff, tko_sr_ff;
   logic [ALT_W-1:0]        alt_sr_ff, clr_sr_ff;
   logic                    ela_gt_ff, ela_eq_ff, air_gt_ff, alt_gt_ff;
   logic                    ela_bit;
   logic                    borrow_in;

   // Multiply and divide.
   logic [THR_W-1:0]        mul_sr_ff;
   logic [PROD_W-1:0]       prod_ff;
   logic [RAMP_W:0]         div_trial;
   logic [RAMP_W:0]         div_diff;

   // Output registers.
   logic                    rsp_valid_ff;
   logic [PHASE_W-1:0]      rsp_phase_ff;
   logic signed [ANG_W-1:0] rsp_pitch_ff, rsp_roll_ff, rsp_yaw_ff;
   logic [THR_W-1:0]        rsp_thr_ff;
   logic                    rsp_early_ff;
   logic signed [ANG_W-1:0] rsp_min_ff, rsp_max_ff;
   logic                    rsp_climb_ff, rsp_started_ff;
   logic                    early;

   // Configuration writes.
   always_ff @(posedge clock) begin
      if (reset) begin
         ramp_time_ff    <= RAMP_TIME_RST;
         takeoff_air_ff  <= TAKEOFF_AIR_RST;
         runway_pitch_ff <= RUNWAY_PITCH_RST;
         max_throttle_ff <= MAX_THROTTLE_RST;
         hold_heading_ff <= HOLD_HEADING_RST;
         pitch_ovr_ff    <= PITCH_OVR_RST;
      end else if (csr_write) begin
         case (csr_index)
            CSR_RAMP_TIME:    ramp_time_ff    <= csr_data[RAMP_W-1:0];
            CSR_TAKEOFF_AIR:  takeoff_air_ff  <= csr_data[AIR_W-1:0];
            CSR_RUNWAY_PITCH: runway_pitch_ff <= $signed(csr_data[ANG_W-1:0]);
            CSR_MAX_THROTTLE: max_throttle_ff <= csr_data[THR_W-1:0];
            CSR_HOLD_HEADING: hold_heading_ff <= csr_data[0];
            CSR_PITCH_OVR:    pitch_ovr_ff    <= csr_data[OVR_W-1:0];
            default: ;
         endcase
      end
   end

   // Control state machine: next state and handshake.
   always_comb begin
      state_in  = state_ff;
      req_stall = 1'b1;
      out_load  = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_stall = reset;
            if (req_valid) state_in = ST_SERIAL;
         end
         ST_SERIAL: begin
            if (cnt_ff == CNT_W'(TIME_W - 1)) state_in = ST_DECIDE;
         end
         ST_DECIDE: begin
            state_in = need_ramp ? ST_MUL : ST_OUT;
         end
         ST_MUL: begin
            if (cnt_ff == CNT_W'(THR_W - 1)) state_in = ST_DIV;
         end
         ST_DIV: begin
            if (cnt_ff == CNT_W'(THR_W - 1)) state_in = ST_OUT;
         end
         ST_OUT: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               out_load = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   assign req_accept = req_valid && !req_stall;
   assign cnt_in     = (state_in != state_ff) ? '0 : cnt_ff + 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end

   // Sequencer state update: commands act at the transfer, updates after the serial pass.
   always_comb begin
      phase_in      = phase_ff;
      start_time_in = start_time_ff;
      held_yaw_in   = held_yaw_ff;
      climbout_in   = climbout_ff;
      init_in       = init_ff;
      if (req_accept) begin
         if (req_command == CMD_RESET) begin
            init_in  = 1'b0;
            phase_in = PH_RAMP;
         end else if (req_command == CMD_START) begin
            held_yaw_in   = req_ext_yaw;
            start_time_in = req_time_us;
            phase_in      = PH_RAMP;
            climbout_in   = 1'b1;
            init_in       = 1'b1;
         end
      end
      if (state_ff == ST_DECIDE && cmd_ff == CMD_UPDATE) begin
         case (phase_ff)
            PH_RAMP:   if (ela_gt_ff) phase_in = PH_RUNWAY;
            PH_RUNWAY: if (air_gt_ff) phase_in = PH_CLIMB;
            PH_CLIMB: begin
               if (alt_gt_ff) begin
                  phase_in    = PH_FLY;
                  climbout_in = 1'b0;
               end
            end
            default: ;
         endcase
      end
   end

   // The ramp value is needed only in phase 0 while the ramp is still running.
   assign need_ramp = (phase_in == PH_RAMP) && (ramp_time_ff != '0) &&
                      !(ela_gt_ff || ela_eq_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PH_RAMP;
         start_time_ff <= '0;
         held_yaw_ff   <= '0;
         climbout_ff   <= 1'b0;
         init_ff       <= 1'b0;
      end else begin
         phase_ff      <= phase_in;
         start_time_ff <= start_time_in;
         held_yaw_ff   <= held_yaw_in;
         climbout_ff   <= climbout_in;
         init_ff       <= init_in;
      end
   end

   // Capture the payload of each transfer.
   always_ff @(posedge clock) begin
      if (req_accept) begin
         cmd_ff   <= req_command;
         pitch_ff <= req_ext_pitch;
         roll_ff  <= req_ext_roll;
         yaw_ff   <= req_ext_yaw;
         thr_ff   <= req_ext_throttle;
         cmin_ff  <= req_climb_min_pitch;
         nmin_ff  <= req_normal_min_pitch;
         nmax_ff  <= req_normal_max_pitch;
      end
   end

   // One bit of the elapsed time per cycle, least significant first.
   assign ela_bit   = now_sr_ff[0] ^ start_sr_ff[0] ^ borrow_ff;
   assign borrow_in = (!now_sr_ff[0] && start_sr_ff[0]) ||
                      (!(now_sr_ff[0] ^ start_sr_ff[0]) && borrow_ff);

   // Serial subtract and compares. A later differing bit overrides an earlier one,
   // so the last difference seen decides each compare. Signed operands are biased.
   always_ff @(posedge clock) begin
      if (req_accept) begin
         now_sr_ff   <= req_time_us;
         start_sr_ff <= (req_command == CMD_START) ? req_time_us : start_time_ff;
         borrow_ff   <= 1'b0;
         ramp_sr_ff  <= ramp_time_ff;
         air_sr_ff   <= req_airspeed;
         tko_sr_ff   <= takeoff_air_ff;
         alt_sr_ff   <= {~req_altitude[ALT_W-1], req_altitude[ALT_W-2:0]};
         clr_sr_ff   <= {~req_clearance_alt[ALT_W-1], req_clearance_alt[ALT_W-2:0]};
         ela_gt_ff   <= 1'b0;
         ela_eq_ff   <= 1'b1;
         air_gt_ff   <= 1'b0;
         alt_gt_ff   <= 1'b0;
      end else if (state_ff == ST_SERIAL) begin
         now_sr_ff   <= {1'b0, now_sr_ff[TIME_W-1:1]};
         start_sr_ff <= {1'b0, start_sr_ff[TIME_W-1:1]};
         borrow_ff   <= borrow_in;
         ramp_sr_ff  <= {1'b0, ramp_sr_ff[RAMP_W-1:1]};
         air_sr_ff   <= {1'b0, air_sr_ff[AIR_W-1:1]};
         tko_sr_ff   <= {1'b0, tko_sr_ff[AIR_W-1:1]};
         alt_sr_ff   <= {1'b0, alt_sr_ff[ALT_W-1:1]};
         clr_sr_ff   <= {1'b0, clr_sr_ff[ALT_W-1:1]};
         if (ela_bit != ramp_sr_ff[0]) begin
            ela_gt_ff <= ela_bit;
            ela_eq_ff <= 1'b0;
         end
         if (air_sr_ff[0] != tko_sr_ff[0]) air_gt_ff <= air_sr_ff[0];
         if (alt_sr_ff[0] != clr_sr_ff[0]) alt_gt_ff <= alt_sr_ff[0];
      end
   end

   // Keep the low bits of the elapsed time for the ramp computation.
   always_ff @(posedge clock) begin
      if (state_ff == ST_SERIAL && cnt_ff < CNT_W'(RAMP_W)) begin
         ela_sr_ff <= {ela_bit, ela_sr_ff[RAMP_W-1:1]};
      end
   end

   // Restoring divide step on the upper part of the product register.
   assign div_trial = {prod_ff[PROD_W-1:THR_W], prod_ff[THR_W-1]};
   assign div_diff  = div_trial - {1'b0, ramp_time_ff};

   // Shift-add multiply by the throttle ceiling, then divide by the ramp time in place.
   always_ff @(posedge clock) begin
      if (state_ff == ST_DECIDE) begin
         mul_sr_ff   <= max_throttle_ff;
         prod_ff     <= '0;
         use_quot_ff <= need_ramp;
      end else if (state_ff == ST_MUL) begin
         mul_sr_ff <= {mul_sr_ff[THR_W-2:0], 1'b0};
         prod_ff   <= {prod_ff[PROD_W-2:0], 1'b0} +
                      (mul_sr_ff[THR_W-1] ? {{THR_W{1'b0}}, ela_sr_ff} : '0);
      end else if (state_ff == ST_DIV) begin
         if (div_diff[RAMP_W]) begin
            prod_ff <= {div_trial[RAMP_W-1:0], prod_ff[THR_W-2:0], 1'b0};
         end else begin
            prod_ff <= {div_diff[RAMP_W-1:0], prod_ff[THR_W-2:0], 1'b1};
         end
      end
   end

   // Result register; it holds while the far side stalls.
   assign early = (phase_ff == PH_RAMP) || (phase_ff == PH_RUNWAY);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         rsp_phase_ff   <= phase_ff;
         rsp_pitch_ff   <= early ? runway_pitch_ff : pitch_ff;
         rsp_roll_ff    <= early ? '0 : roll_ff;
         rsp_yaw_ff     <= (hold_heading_ff && early) ? held_yaw_ff : yaw_ff;
         rsp_early_ff   <= early;
         rsp_min_ff     <= (phase_ff != PH_FLY) ? cmin_ff : nmin_ff;
         rsp_max_ff     <= (phase_ff != PH_FLY && pitch_ovr_ff > PITCH_OVR_MIN) ?
                           $signed({1'b0, pitch_ovr_ff}) : nmax_ff;
         rsp_climb_ff   <= climbout_ff;
         rsp_started_ff <= init_ff;
         case (phase_ff)
            PH_RAMP:   rsp_thr_ff <= use_quot_ff ? prod_ff[THR_W-1:0] : max_throttle_ff;
            PH_RUNWAY: rsp_thr_ff <= max_throttle_ff;
            default:   rsp_thr_ff <= thr_ff;
         endcase
      end
   end

   assign rsp_valid             = rsp_valid_ff;
   assign rsp_phase             = rsp_phase_ff;
   assign rsp_pitch_out         = rsp_pitch_ff;
   assign rsp_roll_out          = rsp_roll_ff;
   assign rsp_yaw_out           = rsp_yaw_ff;
   assign rsp_throttle_out      = rsp_thr_ff;
   assign rsp_yaw_direct        = rsp_early_ff;
   assign rsp_clear_integrators = rsp_early_ff;
   assign rsp_min_pitch_out     = rsp_min_ff;
   assign rsp_max_pitch_out     = rsp_max_ff;
   assign rsp_in_climbout       = rsp_climb_ff;
   assign rsp_started           = rsp_started_ff;

   // The fly phase is reached only by clearing the climbout flag.
   a_fly_no_climbout: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_FLY) |-> !climbout_ff)
      else $error("fly phase with climbout flag set");

   // A transfer always starts the serial pass.
   a_accept_serial: assert property (@(posedge clock) disable iff (reset)
      req_accept |=> (state_ff == ST_SERIAL))
      else $error("accepted transfer did not start the serial pass");

   // A new result never overwrites one that is still stalled.
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      out_load |-> !(rsp_valid_ff && rsp_stall))
      else $error("result register overwritten while stalled");

   // The ramp quotient never exceeds the throttle ceiling.
   a_quot_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_OUT && use_quot_ff) |-> (prod_ff[THR_W-1:0] <= max_throttle_ff))
      else $error("ramp throttle above ceiling");

endmodule

`default_nettype wire
